FILE: src/zscl_pkg.sv
// package for the zoomed sprite chunk layout block
// holds item kinds, layout constants and the sequencer state type; no dependencies
package zscl_pkg;

    // chunk map geometry
    localparam int CHUNKS_PER_ROW = 8;
    localparam int MAP_WORDS      = 32768;
    localparam int CHUNK_ROWS     = 16;
    localparam int MapAw          = $clog2(MAP_WORDS);
    localparam int ColW           = $clog2(CHUNKS_PER_ROW);
    localparam int RowW           = $clog2(CHUNK_ROWS);

    // item kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_DRAW  = 1'b1;

    // coordinate constants
    localparam logic [8:0] DEAD_Y     = 9'h180;
    localparam logic [9:0] WRAP_LIMIT = 10'h140;
    localparam logic [9:0] WRAP_SUB   = 10'h200;
    localparam logic [9:0] Y_BIAS     = 10'd131;  // 3 + 128

    // map word flag
    localparam int INVALID_BIT = 15;

    // layout sequencer
    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_DRAIN,
        S_LAST
    } t_state;

endpackage

FILE: src/zoomed_sprite_chunk_layout.sv
// zoomed sprite chunk layout: chunk map memory plus row layout sequencer
// depends on zscl_pkg
//
// Usage:
//   An item is a transfer at a rising edge with start high and busy low.
//   i_kind selects a chunk map write (0) or the layout of one sprite row (1).
//   A write stores i_map_data at i_map_address in that cycle and never raises
//   busy; writes may follow each other every cycle.
//   A draw decodes the four attribute words, then reads the eight chunk map
//   words of the row, one per cycle from the single read port of the map.
//   Each placement whose map word is valid appears on the o_ ports for one
//   cycle with o_valid high; o_last marks the final placement of the row.
//   One placement is held back until the next valid chunk or the row end so
//   that o_last is known, so a draw keeps busy high through the read, drain and
//   last states, and the last placement shows in the first cycle with busy low.
//   A dead sprite (raw Y of 0x180) gives no placement and does not raise busy.
//   A new draw is taken only once busy is low again; writes go one every cycle while busy is low.
//   The receiver cannot stall: each placement is a transfer in its one cycle.
//   Reset clears the sequencer and the strobe; map contents stay undefined
//   until written and no clearing pass is made.
module zoomed_sprite_chunk_layout
    import zscl_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                i_kind,
    input  logic [14:0]         i_map_address,
    input  logic [15:0]         i_map_data,
    input  logic [15:0]         i_attr_word0,
    input  logic [15:0]         i_attr_word1,
    input  logic [15:0]         i_attr_word2,
    input  logic [15:0]         i_attr_word3,
    input  logic [3:0]          i_row_index,
    output logic                o_valid,
    output logic [14:0]         o_chunk_code,
    output logic [7:0]          o_color,
    output logic                o_flip_x,
    output logic                o_flip_y,
    output logic                o_priority_res,
    output logic signed [9:0]   o_pos_x,
    output logic signed [9:0]   o_pos_y,
    output logic [16:0]         o_scale_x,
    output logic [16:0]         o_scale_y,
    output logic                o_last
);

    // chunk map
    logic [15:0] chunk_map [MAP_WORDS];

    t_state r_state, n_state;

    // decoded sprite attributes
    logic [7:0]      r_tile;
    logic [7:0]      r_color;
    logic            r_fx, r_fy, r_prio;
    logic [7:0]      r_zoomx;
    logic [9:0]      r_x;
    logic [9:0]      r_pos_y;
    logic [3:0]      r_zy;
    logic [RowW-1:0] r_mrow;

    // read sequencing
    logic [ColW-1:0] r_k;
    logic [ColW-1:0] r_kd;
    logic            r_data_vld;
    logic [15:0]     r_rd_data;

    // held placement
    logic            r_pend_vld;
    logic [14:0]     r_pend_code;
    logic [ColW-1:0] r_pend_k;

    // output registers
    logic            r_out_vld;
    logic [14:0]     r_out_code;
    logic [9:0]      r_out_x;
    logic [16:0]     r_out_sx;
    logic            r_out_last;

    logic accept, accept_write, accept_draw;
    logic rd_issue, flush;

    assign busy         = (r_state != S_IDLE);
    assign accept       = start && !busy;
    assign accept_write = accept && (i_kind == KIND_WRITE);
    assign accept_draw  = accept && (i_kind == KIND_DRAW) && (i_attr_word0[8:0] != DEAD_Y);

    // attribute decode at transfer
    logic [7:0]  dec_zoomx, dec_zoomy;
    logic [9:0]  dec_x, dec_ysum, dec_y;
    logic [11:0] row_prod, row1_prod;
    logic [7:0]  row_off, row1_off;

    always_comb begin
        dec_zoomx = {1'b0, i_attr_word1[6:0]} + 8'd1;
        dec_zoomy = {1'b0, i_attr_word0[15:9]} + 8'd1;
        dec_x     = {1'b0, i_attr_word2[8:0]};
        if (dec_x > WRAP_LIMIT) begin
            dec_x = dec_x - WRAP_SUB;
        end
        dec_ysum  = {1'b0, i_attr_word0[8:0]} + Y_BIAS - {2'b0, dec_zoomy};
        dec_y     = (dec_ysum > WRAP_LIMIT) ? (dec_ysum - WRAP_SUB) : dec_ysum;
        row_prod  = {8'b0, i_row_index} * {4'b0, dec_zoomy};
        row1_prod = ({8'b0, i_row_index} + 12'd1) * {4'b0, dec_zoomy};
        row_off   = row_prod[11:4];
        row1_off  = row1_prod[11:4];
    end

    // attribute registers
    always_ff @(posedge i_clk) begin
        if (accept_draw) begin
            r_tile  <= i_attr_word3[7:0];
            r_color <= i_attr_word3[15:8];
            r_fx    <= i_attr_word2[14];
            r_fy    <= i_attr_word1[15];
            r_prio  <= i_attr_word2[15];
            r_zoomx <= dec_zoomx;
            r_x     <= dec_x;
            r_pos_y <= dec_y + {2'b0, row_off};
            r_zy    <= 4'(row1_off - row_off);
            r_mrow  <= i_attr_word1[15] ? (RowW'(CHUNK_ROWS - 1) - i_row_index) : i_row_index;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (accept_draw) n_state = S_READ;
            S_READ:  if (r_k == ColW'(CHUNKS_PER_ROW - 1)) n_state = S_DRAIN;
            S_DRAIN: n_state = S_LAST;
            S_LAST:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        rd_issue = 1'b0;
        flush    = 1'b0;
        unique case (r_state)
            S_IDLE:  ;
            S_READ:  rd_issue = 1'b1;
            S_DRAIN: ;
            S_LAST:  flush = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // map write port and registered read port
    logic [ColW-1:0]  rd_col;
    logic [MapAw-1:0] rd_addr;

    assign rd_col  = r_fx ? (ColW'(CHUNKS_PER_ROW - 1) - r_k) : r_k;
    assign rd_addr = {r_tile, r_mrow, rd_col};

    always_ff @(posedge i_clk) begin
        if (accept_write) begin
            chunk_map[i_map_address] <= i_map_data;
        end
        r_rd_data <= chunk_map[rd_addr];
    end

    // column counter and read data tag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_vld <= 1'b0;
            r_k        <= '0;
        end else begin
            r_data_vld <= rd_issue;
            if (accept_draw) begin
                r_k <= '0;
            end else if (rd_issue) begin
                r_k <= r_k + ColW'(1);
            end
        end
        r_kd <= r_k;
    end

    // hold one placement back so the row end is known
    logic new_chunk, emit;

    assign new_chunk = r_data_vld && !r_rd_data[INVALID_BIT];
    assign emit      = r_pend_vld && (new_chunk || flush);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_vld <= 1'b0;
        end else if (accept_draw || flush) begin
            r_pend_vld <= 1'b0;
        end else if (new_chunk) begin
            r_pend_vld <= 1'b1;
        end
        if (new_chunk) begin
            r_pend_code <= r_rd_data[14:0];
            r_pend_k    <= r_kd;
        end
    end

    // chunk x position and width
    logic [10:0] k_prod, k1_prod;
    logic [7:0]  k_off, k1_off;
    logic [4:0]  zx;

    always_comb begin
        k_prod  = {8'b0, r_pend_k} * {3'b0, r_zoomx};
        k1_prod = ({8'b0, r_pend_k} + 11'd1) * {3'b0, r_zoomx};
        k_off   = k_prod[10:3];
        k1_off  = k1_prod[10:3];
        zx      = 5'(k1_off - k_off);
    end

    // output registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= emit;
        end
        if (emit) begin
            r_out_code <= r_pend_code;
            r_out_x    <= r_x + {2'b0, k_off};
            r_out_sx   <= {zx, 12'b0};
            r_out_last <= flush;
        end
    end

    assign o_valid        = r_out_vld;
    assign o_chunk_code   = r_out_code;
    assign o_color        = r_color;
    assign o_flip_x       = r_fx;
    assign o_flip_y       = r_fy;
    assign o_priority_res = r_prio;
    assign o_pos_x        = r_out_x;
    assign o_pos_y        = r_pos_y;
    assign o_scale_x      = r_out_sx;
    assign o_scale_y      = {r_zy, 13'b0};
    assign o_last         = r_out_last;

endmodule

FILE: tb/zscl_checker.sv
// placement checker for the zoomed sprite chunk layout block
// watches item transfers and placement strobes, predicts placements and compares them
// depends on zscl_pkg
module zscl_checker
    import zscl_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  logic                busy,
    input  logic                i_kind,
    input  logic [14:0]         i_map_address,
    input  logic [15:0]         i_map_data,
    input  logic [15:0]         i_attr_word0,
    input  logic [15:0]         i_attr_word1,
    input  logic [15:0]         i_attr_word2,
    input  logic [15:0]         i_attr_word3,
    input  logic [3:0]          i_row_index,
    input  logic                o_valid,
    input  logic [14:0]         o_chunk_code,
    input  logic [7:0]          o_color,
    input  logic                o_flip_x,
    input  logic                o_flip_y,
    input  logic                o_priority_res,
    input  logic signed [9:0]   o_pos_x,
    input  logic signed [9:0]   o_pos_y,
    input  logic [16:0]         o_scale_x,
    input  logic [16:0]         o_scale_y,
    input  logic                o_last,
    output int                  o_fail_count,
    output int                  o_pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // one zoomed chunk placement as the block emits it
    typedef struct packed {
        logic [14:0]        chunk_code;
        logic [7:0]         color;
        logic               flip_x;
        logic               flip_y;
        logic               priority_res;
        logic signed [9:0]  pos_x;
        logic signed [9:0]  pos_y;
        logic [16:0]        scale_x;
        logic [16:0]        scale_y;
        logic               last;
    } t_placement;

    t_placement  expected_placements[$];
    t_placement  oldest;
    logic [15:0] shadow_map [MAP_WORDS];

    initial begin
        o_fail_count    = 0;
        o_pending_count = 0;
    end

    // lay out one sprite row against the shadow map and queue its placements
    task automatic predict_row_layout(input logic [15:0] w0, input logic [15:0] w1,
                                      input logic [15:0] w2, input logic [15:0] w3,
                                      input logic [3:0] row);
        int          zoom_x;
        int          zoom_y;
        int          base_x;
        int          base_y;
        int          row_y;
        int          row_h;
        int          col_x;
        int          col_w;
        logic [3:0]  map_row;
        logic [2:0]  map_col;
        logic [15:0] word;
        t_placement  p;
        t_placement  row_placements[$];

        if (w0[8:0] == DEAD_Y) return;

        zoom_x = int'(w1[6:0]) + 1;
        zoom_y = int'(w0[15:9]) + 1;
        base_x = int'(w2[8:0]);
        base_y = int'(w0[8:0]) + int'(Y_BIAS) - zoom_y;
        // coordinates past the right or bottom edge wrap to negative
        if (base_x > int'(WRAP_LIMIT)) base_x -= int'(WRAP_SUB);
        if (base_y > int'(WRAP_LIMIT)) base_y -= int'(WRAP_SUB);

        map_row = w1[15] ? 4'(CHUNK_ROWS - 1 - int'(row)) : row;
        row_y   = base_y + (int'(row) * zoom_y) / CHUNK_ROWS;
        row_h   = ((int'(row) + 1) * zoom_y) / CHUNK_ROWS - (int'(row) * zoom_y) / CHUNK_ROWS;

        // walk the columns in screen order, skipping invalid chunks
        for (int k = 0; k < CHUNKS_PER_ROW; k++) begin
            map_col = w2[14] ? 3'(CHUNKS_PER_ROW - 1 - k) : 3'(k);
            word    = shadow_map[{w3[7:0], map_row, map_col}];
            if (word[INVALID_BIT]) continue;
            col_x = base_x + (k * zoom_x) / CHUNKS_PER_ROW;
            col_w = ((k + 1) * zoom_x) / CHUNKS_PER_ROW - (k * zoom_x) / CHUNKS_PER_ROW;
            p.chunk_code   = word[14:0];
            p.color        = w3[15:8];
            p.flip_x       = w2[14];
            p.flip_y       = w1[15];
            p.priority_res = w2[15];
            p.pos_x        = 10'(col_x);
            p.pos_y        = 10'(row_y);
            p.scale_x      = 17'(col_w << 12);
            p.scale_y      = 17'(row_h << 13);
            p.last         = 1'b0;
            row_placements.push_back(p);
        end

        // the final valid chunk of the row carries last
        for (int i = 0; i < row_placements.size(); i++) begin
            p      = row_placements[i];
            p.last = (i == row_placements.size() - 1);
            expected_placements.push_back(p);
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            o_fail_count++;
        end
    endtask

    // compare strobed placements, then track the item transfer of this edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) begin
                if (expected_placements.size() == 0) begin
                    $display("%0t ns: placement with none expected, actual code %0d",
                             $time, o_chunk_code);
                    o_fail_count++;
                end else begin
                    oldest = expected_placements.pop_front();
                    check_field("chunk_code", oldest.chunk_code, o_chunk_code);
                    check_field("color", oldest.color, o_color);
                    check_field("flip_x", oldest.flip_x, o_flip_x);
                    check_field("flip_y", oldest.flip_y, o_flip_y);
                    check_field("priority_res", oldest.priority_res, o_priority_res);
                    check_field("pos_x", $signed(oldest.pos_x), $signed(o_pos_x));
                    check_field("pos_y", $signed(oldest.pos_y), $signed(o_pos_y));
                    check_field("scale_x", oldest.scale_x, o_scale_x);
                    check_field("scale_y", oldest.scale_y, o_scale_y);
                    check_field("last", oldest.last, o_last);
                end
            end
            if (start && !busy) begin
                if (i_kind == KIND_WRITE) begin
                    shadow_map[i_map_address] = i_map_data;
                end else begin
                    predict_row_layout(i_attr_word0, i_attr_word1, i_attr_word2,
                                       i_attr_word3, i_row_index);
                end
            end
            o_pending_count = expected_placements.size();
        end
    end

endmodule

FILE: tb/zoomed_sprite_chunk_layout_test.sv
// top of the zoomed sprite chunk layout testbench: clock, reset, stimulus and verdict
// depends on zscl_pkg, zoomed_sprite_chunk_layout and zscl_checker
module zoomed_sprite_chunk_layout_test;
    import zscl_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET  = 420;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 16;

    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                start          = 1'b0;
    logic                busy;
    logic                i_kind         = KIND_WRITE;
    logic [14:0]         i_map_address  = '0;
    logic [15:0]         i_map_data     = '0;
    logic [15:0]         i_attr_word0   = '0;
    logic [15:0]         i_attr_word1   = '0;
    logic [15:0]         i_attr_word2   = '0;
    logic [15:0]         i_attr_word3   = '0;
    logic [3:0]          i_row_index    = '0;
    logic                o_valid;
    logic [14:0]         o_chunk_code;
    logic [7:0]          o_color;
    logic                o_flip_x;
    logic                o_flip_y;
    logic                o_priority_res;
    logic signed [9:0]   o_pos_x;
    logic signed [9:0]   o_pos_y;
    logic [16:0]         o_scale_x;
    logic [16:0]         o_scale_y;
    logic                o_last;

    int fail_count;
    int pending_count;
    int cycle_count  = 0;
    int write_count  = 0;
    int draw_count   = 0;
    int dead_count   = 0;
    int burst_left   = 0;

    // map rows whose eight words have all been written: {tile, map row}
    logic [11:0] ready_rows[$];

    zoomed_sprite_chunk_layout DUT (.*);

    zscl_checker checker_inst (
        .*,
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count)
    );

    always #4 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // one item transfer after a random gap; bursts with no gap now and then
    task automatic send_item(input logic kind, input logic [14:0] addr,
                             input logic [15:0] data,
                             input logic [15:0] w0, input logic [15:0] w1,
                             input logic [15:0] w2, input logic [15:0] w3,
                             input logic [3:0] row);
        int gap;

        if (burst_left > 0) begin
            burst_left--;
            gap = 0;
        end else begin
            gap = $urandom_range(0, 8);
            if ($urandom_range(0, 19) == 0) burst_left = $urandom_range(8, 32);
        end
        repeat (gap) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start         <= 1'b1;
        i_kind        <= kind;
        i_map_address <= addr;
        i_map_data    <= data;
        i_attr_word0  <= w0;
        i_attr_word1  <= w1;
        i_attr_word2  <= w2;
        i_attr_word3  <= w3;
        i_row_index   <= row;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (kind == KIND_WRITE) begin
            write_count++;
        end else begin
            draw_count++;
            if (w0[8:0] == DEAD_Y) dead_count++;
        end
    endtask

    // map write with random don't-care attribute fields
    task automatic write_word(input logic [14:0] addr, input logic [15:0] data);
        send_item(KIND_WRITE, addr, data, 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom), 4'($urandom));
    endtask

    // row layout with random don't-care map fields
    task automatic draw_sprite(input logic [15:0] w0, input logic [15:0] w1,
                               input logic [15:0] w2, input logic [15:0] w3,
                               input logic [3:0] row);
        send_item(KIND_DRAW, 15'($urandom), 16'($urandom), w0, w1, w2, w3, row);
    endtask

    // fill the eight words of one map row, some rows valid, some mixed, few all invalid
    task automatic write_map_row(input logic [7:0] tile, input logic [3:0] map_row);
        int          style;
        logic [15:0] word;

        style = $urandom_range(0, 9);
        for (int k = 0; k < CHUNKS_PER_ROW; k++) begin
            word = 16'($urandom);
            if (style == 0) word[INVALID_BIT] = 1'b1;
            else if (style < 5) word[INVALID_BIT] = 1'b0;
            write_word({tile, map_row, 3'(k)}, word);
        end
        ready_rows.push_back({tile, map_row});
    endtask

    // random sprite over a written map row; row index follows the vertical flip
    task automatic draw_ready_row(input logic [11:0] row_id, input bit dead);
        logic [15:0] w0;
        logic [15:0] w1;

        w0 = 16'($urandom);
        w1 = 16'($urandom);
        if (dead) w0[8:0] = DEAD_Y;
        draw_sprite(w0, w1, 16'($urandom), {8'($urandom), row_id[11:4]},
                    w1[15] ? 4'(CHUNK_ROWS - 1 - int'(row_id[3:0])) : row_id[3:0]);
    endtask

    initial begin
        logic [15:0] pattern [CHUNKS_PER_ROW] = '{16'h0000, 16'h7fff, 16'h8000, 16'h1234,
                                                  16'hffff, 16'h5a5a, 16'h8001, 16'h2aaa};
        int choice;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: a mixed row for tile 0 and an all-invalid row for tile 255
        for (int k = 0; k < CHUNKS_PER_ROW; k++) write_word(15'(k), pattern[k]);
        for (int k = 0; k < CHUNKS_PER_ROW; k++)
            write_word({8'hff, 4'hf, 3'(k)}, 16'h8000 | 16'($urandom));
        ready_rows.push_back({8'h00, 4'h0});
        ready_rows.push_back({8'hff, 4'hf});

        // smallest zoom, origin
        draw_sprite(16'h0000, 16'h0000, 16'h0000, 16'h0000, 4'd0);
        // largest zoom, flip x, coordinates just at the wrap limit
        draw_sprite({7'h7f, 9'h13d}, 16'h007f, 16'h4140, 16'hff00, 4'd0);
        // flip y, priority, both coordinates just past the wrap limit
        draw_sprite({7'h7f, 9'h13e}, 16'h807f, 16'h8141, 16'h5a00, 4'd15);
        // every bit of the first three attribute words set
        draw_sprite(16'hffff, 16'hffff, 16'hffff, 16'h0000, 4'd15);
        // dead sprites
        draw_sprite({7'h2a, DEAD_Y}, 16'h0015, 16'h0033, 16'h0000, 4'd0);
        draw_sprite({7'h7f, DEAD_Y}, 16'hffff, 16'hffff, 16'hff00, 4'd15);
        // row with every chunk invalid
        draw_sprite(16'h1234, 16'h8040, 16'h2055, 16'h33ff, 4'd0);
        // ignored x bits set, mid zoom
        draw_sprite(16'h8100, 16'h0040, 16'h20aa, 16'hc300, 4'd0);

        // random: fresh rows laid out right away, as many redraws, plus noise and dead sprites
        while (write_count + draw_count < ITEM_TARGET) begin
            choice = $urandom_range(0, 9);
            if (choice < 4) begin
                write_map_row(8'($urandom), 4'($urandom));
                draw_ready_row(ready_rows[ready_rows.size() - 1], 1'b0);
            end else if (choice < 8) begin
                draw_ready_row(ready_rows[$urandom_range(0, ready_rows.size() - 1)], 1'b0);
            end else if (choice == 8) begin
                write_word(15'($urandom), 16'($urandom));
            end else begin
                draw_ready_row(ready_rows[$urandom_range(0, ready_rows.size() - 1)], 1'b1);
            end
        end
        start <= 1'b0;

        // let every expected placement arrive, then a short drain
        do @(negedge i_clk); while (pending_count != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("ran %0d map writes and %0d row layouts, %0d of them dead sprites",
                 write_count, draw_count, dead_count);
        $display("layouts covered flips, zoom extremes, coordinate wrap and invalid chunks");
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

FILE: sim.f
src/zscl_pkg.sv
src/zoomed_sprite_chunk_layout.sv
tb/zscl_checker.sv
tb/zoomed_sprite_chunk_layout_test.sv
